FILE: rtl/assert_macros.svh
// Assertion macros used by the rate controller core.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// A condition that must hold at every rising clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// A condition that implies another in the same cycle.
`define ASSERT_IMPL(label, clk, rst_n, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) else $error(msg);
// A condition that implies another in the next cycle.
`define ASSERT_NEXT(label, clk, rst_n, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) else $error(msg);
`else
`define ASSERT_ALWAYS(label, clk, rst_n, prop, msg)
`define ASSERT_IMPL(label, clk, rst_n, cond, prop, msg)
`define ASSERT_NEXT(label, clk, rst_n, cond, prop, msg)
`endif
`endif

FILE: rtl/ladrc_pkg.sv
// Types, constants and helper functions for the rate observer controller.
package ladrc_pkg;

    // Word widths: state and gains, multiplier operands, sum accumulator.
    localparam int DATA_W    = 48;
    localparam int OP_W      = 49;
    localparam int ACC_W     = 52;
    localparam int PART_W    = 25;
    localparam int MUL_ACC_W = 99;
    localparam int CFG_IDX_W = 3;

    // Q24.24 unity and Q2.14 drive limits.
    localparam longint ONE_Q = 64'sd16777216;
    localparam logic signed [DATA_W-1:0] ONE_Q48   = 48'sd16777216;
    localparam logic signed [DATA_W-1:0] MAX48     = 48'sh7FFF_FFFF_FFFF;
    localparam logic signed [DATA_W-1:0] MIN48     = 48'sh8000_0000_0000;
    localparam logic signed [15:0]       DRIVE_MAX = 16'sd16384;
    localparam logic signed [15:0]       DRIVE_MIN = -16'sd16384;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_OBS_GAIN_POS   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_OBS_GAIN_VEL   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_OBS_GAIN_DIST  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_PROP_GAIN      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_DERIV_GAIN     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_INV_PLANT_GAIN = 3'd5;

    // Input beat.
    typedef struct packed {
        logic signed [31:0] measured_rate;
        logic signed [31:0] rate_setpoint;
        logic signed [15:0] applied_drive;
    } in_t;

    // Result beat.
    typedef struct packed {
        logic signed [15:0]       drive;
        logic                     drive_clipped;
        logic signed [DATA_W-1:0] est_rate;
        logic signed [DATA_W-1:0] est_rate_deriv;
        logic signed [DATA_W-1:0] est_disturbance;
    } out_t;

    // Gain registers as seen by the sequencer.
    typedef struct packed {
        logic [DATA_W-1:0] obs_gain_pos;
        logic [DATA_W-1:0] obs_gain_vel;
        logic [DATA_W-1:0] obs_gain_dist;
        logic [DATA_W-1:0] prop_gain;
        logic [DATA_W-1:0] deriv_gain;
        logic [DATA_W-1:0] inv_plant_gain;
    } gains_t;

    // Request into and response from the shared multiplier.
    typedef struct packed {
        logic                   start;
        logic signed [OP_W-1:0] a;
        logic signed [OP_W-1:0] b;
    } mul_req_t;

    typedef struct packed {
        logic                     done;
        logic signed [DATA_W-1:0] res;
    } mul_rsp_t;

    // Sequencer status toward the top level.
    typedef struct packed {
        logic idle;
        logic res_valid;
    } core_status_t;

    // Sequencer states: idle, one per product, then the result hand-off.
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_P1A,
        ST_P1B,
        ST_P1C,
        ST_P2A,
        ST_P2B,
        ST_Z1,
        ST_Z2,
        ST_Z3,
        ST_KP,
        ST_KD,
        ST_V,
        ST_OUT
    } st_t;

    // Sign-extend a 48-bit value to the accumulator width.
    function automatic logic signed [ACC_W-1:0] sx48(input logic signed [DATA_W-1:0] v);
        return {{(ACC_W-DATA_W){v[DATA_W-1]}}, v};
    endfunction

    // Saturate an accumulator value to signed 48 bits.
    function automatic logic signed [DATA_W-1:0] sat48(input logic signed [ACC_W-1:0] v);
        logic all_zero;
        logic all_one;
        all_zero = ~|v[ACC_W-1:DATA_W-1];
        all_one  = &v[ACC_W-1:DATA_W-1];
        if (all_zero || all_one)
            return v[DATA_W-1:0];
        else if (v[ACC_W-1])
            return MIN48;
        else
            return MAX48;
    endfunction

endpackage

FILE: rtl/ladrc_mul.sv
// Shared Q24.24 multiplier: four 25x25 partial products, rounding and saturation.
module ladrc_mul (
    input  logic                clk,
    input  logic                rst_n,
    input  ladrc_pkg::mul_req_t req,
    output ladrc_pkg::mul_rsp_t rsp
);

    logic                                busy_reg, busy_next;
    logic                                fin_reg, fin_next;
    logic [1:0]                          cnt_reg, cnt_next;
    logic                                neg_reg, neg_next;
    logic [ladrc_pkg::OP_W-1:0]          mag_a_reg, mag_a_next;
    logic [ladrc_pkg::OP_W-1:0]          mag_b_reg, mag_b_next;
    logic [ladrc_pkg::MUL_ACC_W-1:0]     acc_reg, acc_next;

    logic [ladrc_pkg::PART_W-1:0]        part_a;
    logic [ladrc_pkg::PART_W-1:0]        part_b;
    logic [2*ladrc_pkg::PART_W-1:0]      pp;
    logic [ladrc_pkg::MUL_ACC_W-1:0]     pp_sh;
    logic                                ovf;
    logic [ladrc_pkg::DATA_W-1:0]        q_pos;

    // Partial product selected by the pass count; hi chunks carry 24 bits.
    always_comb
    begin
        part_a = cnt_reg[1] ? {1'b0, mag_a_reg[ladrc_pkg::OP_W-1:ladrc_pkg::PART_W]}
                            : mag_a_reg[ladrc_pkg::PART_W-1:0];
        part_b = cnt_reg[0] ? {1'b0, mag_b_reg[ladrc_pkg::OP_W-1:ladrc_pkg::PART_W]}
                            : mag_b_reg[ladrc_pkg::PART_W-1:0];
        pp     = part_a * part_b;
        case (cnt_reg)
            2'd0:    pp_sh = ladrc_pkg::MUL_ACC_W'(pp);
            2'd3:    pp_sh = ladrc_pkg::MUL_ACC_W'(pp) << (2 * ladrc_pkg::PART_W);
            default: pp_sh = ladrc_pkg::MUL_ACC_W'(pp) << ladrc_pkg::PART_W;
        endcase
    end

    // Pass sequencing; the accumulator starts at the rounding bias.
    always_comb
    begin
        busy_next  = busy_reg;
        fin_next   = 1'b0;
        cnt_next   = cnt_reg;
        neg_next   = neg_reg;
        mag_a_next = mag_a_reg;
        mag_b_next = mag_b_reg;
        acc_next   = acc_reg;
        if (req.start)
        begin
            busy_next  = 1'b1;
            cnt_next   = 2'd0;
            neg_next   = req.a[ladrc_pkg::OP_W-1] ^ req.b[ladrc_pkg::OP_W-1];
            mag_a_next = req.a[ladrc_pkg::OP_W-1] ? ladrc_pkg::OP_W'(0 - req.a) : req.a;
            mag_b_next = req.b[ladrc_pkg::OP_W-1] ? ladrc_pkg::OP_W'(0 - req.b) : req.b;
            acc_next   = ladrc_pkg::MUL_ACC_W'(1) << 23;
        end
        else if (busy_reg)
        begin
            acc_next = acc_reg + pp_sh;
            cnt_next = cnt_reg + 2'd1;
            if (cnt_reg == 2'd3)
            begin
                busy_next = 1'b0;
                fin_next  = 1'b1;
            end
        end
    end

    // Drop 24 fraction bits, saturate on magnitude, then apply the sign.
    always_comb
    begin
        ovf   = |acc_reg[ladrc_pkg::MUL_ACC_W-1:71];
        q_pos = {1'b0, acc_reg[70:24]};
        rsp.done = fin_reg;
        if (ovf)
            rsp.res = neg_reg ? ladrc_pkg::MIN48 : ladrc_pkg::MAX48;
        else
            rsp.res = neg_reg ? ladrc_pkg::DATA_W'(0 - q_pos) : q_pos;
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            fin_reg  <= 1'b0;
            cnt_reg  <= 2'd0;
        end
        else
        begin
            busy_reg <= busy_next;
            fin_reg  <= fin_next;
            cnt_reg  <= cnt_next;
        end
    end

    // Operand and accumulator registers.
    always_ff @(posedge clk)
    begin
        neg_reg   <= neg_next;
        mag_a_reg <= mag_a_next;
        mag_b_reg <= mag_b_next;
        acc_reg   <= acc_next;
    end

endmodule

FILE: rtl/ladrc_core.sv
// Sequencer and sum datapath: observer update and control law through the shared multiplier.
`include "assert_macros.svh"

module ladrc_core #(
    parameter int SAMPLE_RATE_HZ = 250
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    input  ladrc_pkg::in_t          in_item,
    input  ladrc_pkg::gains_t       gains,
    input  logic                    res_ready,
    output ladrc_pkg::core_status_t status,
    output ladrc_pkg::out_t         res_data,
    output ladrc_pkg::mul_req_t     mul_req,
    input  ladrc_pkg::mul_rsp_t     mul_rsp
);

    // Sample period and half its square in Q24.24, rounded to nearest.
    localparam longint TS_Q   = (2 * ladrc_pkg::ONE_Q + SAMPLE_RATE_HZ) / (2 * SAMPLE_RATE_HZ);
    localparam longint TS2H_Q = (ladrc_pkg::ONE_Q + SAMPLE_RATE_HZ * SAMPLE_RATE_HZ)
                                / (2 * SAMPLE_RATE_HZ * SAMPLE_RATE_HZ);
    localparam logic signed [ladrc_pkg::OP_W-1:0] TS_OP   = ladrc_pkg::OP_W'(TS_Q);
    localparam logic signed [ladrc_pkg::OP_W-1:0] TS2H_OP = ladrc_pkg::OP_W'(TS2H_Q);

    ladrc_pkg::st_t                          state_reg, state_next;
    logic                                    issued_reg, issued_next;
    ladrc_pkg::in_t                          in_reg, in_next;
    logic signed [ladrc_pkg::DATA_W-1:0]     z1_reg, z1_next;
    logic signed [ladrc_pkg::DATA_W-1:0]     z2_reg, z2_next;
    logic signed [ladrc_pkg::DATA_W-1:0]     z3_reg, z3_next;
    logic signed [ladrc_pkg::DATA_W-1:0]     p1_reg, p1_next;
    logic signed [ladrc_pkg::DATA_W-1:0]     p2_reg, p2_next;
    logic signed [ladrc_pkg::OP_W-1:0]       e_reg, e_next;
    logic signed [ladrc_pkg::ACC_W-1:0]      acc_reg, acc_next;
    logic signed [ladrc_pkg::DATA_W-1:0]     t_reg, t_next;
    logic signed [ladrc_pkg::DATA_W-1:0]     v_reg, v_next;

    logic signed [ladrc_pkg::ACC_W-1:0]      m;
    logic signed [ladrc_pkg::ACC_W-1:0]      y_w;
    logic signed [ladrc_pkg::ACC_W-1:0]      r_w;
    logic signed [ladrc_pkg::OP_W-1:0]       u_op;
    logic signed [ladrc_pkg::ACC_W-1:0]      diff;
    logic                                    prod_state;

    logic                                    clip_hi;
    logic                                    clip_lo;
    logic [ladrc_pkg::DATA_W-1:0]            v_mag;
    logic [25:0]                             v_rnd;
    logic [15:0]                             d_mag;

    // Widened inputs: rates to Q24.24, applied drive to Q24.24.
    assign m    = ladrc_pkg::sx48(mul_rsp.res);
    assign y_w  = {{12{in_reg.measured_rate[31]}}, in_reg.measured_rate, 8'b0};
    assign r_w  = {{12{in_reg.rate_setpoint[31]}}, in_reg.rate_setpoint, 8'b0};
    assign u_op = {{23{in_reg.applied_drive[15]}}, in_reg.applied_drive, 10'b0};
    assign diff = r_w - ladrc_pkg::sx48(z1_reg);

    assign prod_state = (state_reg != ladrc_pkg::ST_IDLE) && (state_reg != ladrc_pkg::ST_OUT);

    // Next state, operand selection and sum updates.
    always_comb
    begin
        state_next  = state_reg;
        issued_next = issued_reg;
        in_next     = in_reg;
        z1_next     = z1_reg;
        z2_next     = z2_reg;
        z3_next     = z3_reg;
        p1_next     = p1_reg;
        p2_next     = p2_reg;
        e_next      = e_reg;
        acc_next    = acc_reg;
        t_next      = t_reg;
        v_next      = v_reg;
        mul_req.a   = '0;
        mul_req.b   = '0;

        unique case (state_reg)
            ladrc_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    in_next    = in_item;
                    state_next = ladrc_pkg::ST_P1A;
                end
            end
            // Predicted rate: z1 + Ts*z2 + Ts^2/2*z3 + Ts^2/2*u.
            ladrc_pkg::ST_P1A:
            begin
                mul_req.a = TS_OP;
                mul_req.b = {z2_reg[ladrc_pkg::DATA_W-1], z2_reg};
                if (mul_rsp.done)
                begin
                    acc_next   = ladrc_pkg::sx48(z1_reg) + m;
                    state_next = ladrc_pkg::ST_P1B;
                end
            end
            ladrc_pkg::ST_P1B:
            begin
                mul_req.a = TS2H_OP;
                mul_req.b = {z3_reg[ladrc_pkg::DATA_W-1], z3_reg};
                if (mul_rsp.done)
                begin
                    acc_next   = acc_reg + m;
                    state_next = ladrc_pkg::ST_P1C;
                end
            end
            ladrc_pkg::ST_P1C:
            begin
                mul_req.a = TS2H_OP;
                mul_req.b = u_op;
                if (mul_rsp.done)
                begin
                    p1_next    = ladrc_pkg::sat48(acc_reg + m);
                    state_next = ladrc_pkg::ST_P2A;
                end
            end
            // Predicted derivative: z2 + Ts*z3 + Ts*u.
            ladrc_pkg::ST_P2A:
            begin
                mul_req.a = TS_OP;
                mul_req.b = {z3_reg[ladrc_pkg::DATA_W-1], z3_reg};
                if (mul_rsp.done)
                begin
                    acc_next   = ladrc_pkg::sx48(z2_reg) + m;
                    state_next = ladrc_pkg::ST_P2B;
                end
            end
            ladrc_pkg::ST_P2B:
            begin
                mul_req.a = TS_OP;
                mul_req.b = u_op;
                if (mul_rsp.done)
                begin
                    p2_next    = ladrc_pkg::sat48(acc_reg + m);
                    e_next     = ladrc_pkg::OP_W'(y_w - ladrc_pkg::sx48(p1_reg));
                    state_next = ladrc_pkg::ST_Z1;
                end
            end
            // Observer correction by the output error.
            ladrc_pkg::ST_Z1:
            begin
                mul_req.a = {1'b0, gains.obs_gain_pos};
                mul_req.b = e_reg;
                if (mul_rsp.done)
                begin
                    z1_next    = ladrc_pkg::sat48(ladrc_pkg::sx48(p1_reg) + m);
                    state_next = ladrc_pkg::ST_Z2;
                end
            end
            ladrc_pkg::ST_Z2:
            begin
                mul_req.a = {1'b0, gains.obs_gain_vel};
                mul_req.b = e_reg;
                if (mul_rsp.done)
                begin
                    z2_next    = ladrc_pkg::sat48(ladrc_pkg::sx48(p2_reg) + m);
                    state_next = ladrc_pkg::ST_Z3;
                end
            end
            ladrc_pkg::ST_Z3:
            begin
                mul_req.a = {1'b0, gains.obs_gain_dist};
                mul_req.b = e_reg;
                if (mul_rsp.done)
                begin
                    z3_next    = ladrc_pkg::sat48(ladrc_pkg::sx48(z3_reg) + m);
                    state_next = ladrc_pkg::ST_KP;
                end
            end
            // Control law: kp*(r - z1) - kd*z2 - z3, then times 1/b.
            ladrc_pkg::ST_KP:
            begin
                mul_req.a = {1'b0, gains.prop_gain};
                mul_req.b = diff[ladrc_pkg::OP_W-1:0];
                if (mul_rsp.done)
                begin
                    acc_next   = m;
                    state_next = ladrc_pkg::ST_KD;
                end
            end
            ladrc_pkg::ST_KD:
            begin
                mul_req.a = {1'b0, gains.deriv_gain};
                mul_req.b = {z2_reg[ladrc_pkg::DATA_W-1], z2_reg};
                if (mul_rsp.done)
                begin
                    t_next     = ladrc_pkg::sat48(acc_reg - m - ladrc_pkg::sx48(z3_reg));
                    state_next = ladrc_pkg::ST_V;
                end
            end
            ladrc_pkg::ST_V:
            begin
                mul_req.a = {t_reg[ladrc_pkg::DATA_W-1], t_reg};
                mul_req.b = {1'b0, gains.inv_plant_gain};
                if (mul_rsp.done)
                begin
                    v_next     = mul_rsp.res;
                    state_next = ladrc_pkg::ST_OUT;
                end
            end
            ladrc_pkg::ST_OUT:
            begin
                if (res_ready)
                    state_next = ladrc_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = ladrc_pkg::ST_IDLE;
            end
        endcase

        // One multiplier start per product state.
        mul_req.start = prod_state && !issued_reg;
        if (mul_req.start)
            issued_next = 1'b1;
        if (mul_rsp.done)
            issued_next = 1'b0;
    end

    // Drive conversion: clamp to +-1.0, else round Q24.24 to Q2.14.
    always_comb
    begin
        clip_hi = v_reg > ladrc_pkg::ONE_Q48;
        clip_lo = v_reg < -ladrc_pkg::ONE_Q48;
        v_mag   = v_reg[ladrc_pkg::DATA_W-1] ? ladrc_pkg::DATA_W'(0 - v_reg) : v_reg;
        v_rnd   = {1'b0, v_mag[24:0]} + 26'd512;
        d_mag   = v_rnd[25:10];

        res_data.est_rate        = z1_reg;
        res_data.est_rate_deriv  = z2_reg;
        res_data.est_disturbance = z3_reg;
        res_data.drive_clipped   = clip_hi || clip_lo;
        if (clip_hi)
            res_data.drive = ladrc_pkg::DRIVE_MAX;
        else if (clip_lo)
            res_data.drive = ladrc_pkg::DRIVE_MIN;
        else
            res_data.drive = v_reg[ladrc_pkg::DATA_W-1] ? 16'(0 - d_mag) : d_mag;
    end

    assign status.idle      = (state_reg == ladrc_pkg::ST_IDLE);
    assign status.res_valid = (state_reg == ladrc_pkg::ST_OUT);

    // Control and observer state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ladrc_pkg::ST_IDLE;
            issued_reg <= 1'b0;
            z1_reg     <= '0;
            z2_reg     <= '0;
            z3_reg     <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            issued_reg <= issued_next;
            z1_reg     <= z1_next;
            z2_reg     <= z2_next;
            z3_reg     <= z3_next;
        end
    end

    // Working registers of one item.
    always_ff @(posedge clk)
    begin
        in_reg  <= in_next;
        p1_reg  <= p1_next;
        p2_reg  <= p2_next;
        e_reg   <= e_next;
        acc_reg <= acc_next;
        t_reg   <= t_next;
        v_reg   <= v_next;
    end

    // A multiplier result only arrives while a product is outstanding.
    `ASSERT_IMPL(a_done_in_product, clk, rst_n, mul_rsp.done, prod_state && issued_reg, "multiplier result outside a product step")
    // A multiplier start is never repeated back to back, as each product step starts it once.
    `ASSERT_NEXT(a_single_start, clk, rst_n, mul_req.start, !mul_req.start, "multiplier started twice")
    // The delivered drive stays within plus and minus one.
    `ASSERT_IMPL(a_drive_range, clk, rst_n, status.res_valid, (res_data.drive <= ladrc_pkg::DRIVE_MAX) && (res_data.drive >= ladrc_pkg::DRIVE_MIN), "drive out of range")
    // A clipped drive sits on a rail.
    `ASSERT_IMPL(a_clip_rail, clk, rst_n, status.res_valid && res_data.drive_clipped, (res_data.drive == ladrc_pkg::DRIVE_MAX) || (res_data.drive == ladrc_pkg::DRIVE_MIN), "clipped drive off the rail")
    // Handing off the result returns the sequencer to idle.
    `ASSERT_NEXT(a_out_to_idle, clk, rst_n, status.res_valid && res_ready, state_reg == ladrc_pkg::ST_IDLE, "sequencer did not return to idle")

endmodule

FILE: rtl/ladrc_rate_observer_controller_top.sv
// Top level of one rate controller axis: config registers, sequencer, multiplier, output register.
// Each item is accepted, runs eleven products through one shared multiplier (each one issue,
// four 25x25 passes, result), then is handed off; an input beat is taken only while idle, so
// a new item is not accepted before the previous result has been handed off.
// The output register holds a finished beat while the next item runs; a longer stall holds
// the sequencer in its hand-off step. Reset clears observer state, gains and handshake state.
module ladrc_rate_observer_controller_top #(
    parameter int SAMPLE_RATE_HZ = 250
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  ladrc_pkg::in_t                     in_data,
    output logic                               out_valid,
    input  logic                               out_stall,
    output ladrc_pkg::out_t                    out_data,
    input  logic                               cfg_we,
    input  logic [ladrc_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [ladrc_pkg::DATA_W-1:0]       cfg_data
);

    ladrc_pkg::gains_t       gains_reg, gains_next;
    logic                    out_valid_reg, out_valid_next;
    ladrc_pkg::out_t         out_data_reg, out_data_next;

    ladrc_pkg::core_status_t status;
    ladrc_pkg::out_t         res_data;
    ladrc_pkg::mul_req_t     mul_req;
    ladrc_pkg::mul_rsp_t     mul_rsp;
    logic                    in_accept;
    logic                    res_ready;

    // Handshake: busy while an item is in flight.
    assign in_stall  = !status.idle;
    assign in_accept = in_valid && !in_stall;
    assign res_ready = !out_valid_reg || !out_stall;

    // Gain register writes; indexes past the list are ignored.
    always_comb
    begin
        gains_next = gains_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                ladrc_pkg::CFG_OBS_GAIN_POS:   gains_next.obs_gain_pos   = cfg_data;
                ladrc_pkg::CFG_OBS_GAIN_VEL:   gains_next.obs_gain_vel   = cfg_data;
                ladrc_pkg::CFG_OBS_GAIN_DIST:  gains_next.obs_gain_dist  = cfg_data;
                ladrc_pkg::CFG_PROP_GAIN:      gains_next.prop_gain      = cfg_data;
                ladrc_pkg::CFG_DERIV_GAIN:     gains_next.deriv_gain     = cfg_data;
                ladrc_pkg::CFG_INV_PLANT_GAIN: gains_next.inv_plant_gain = cfg_data;
                default:                       gains_next = gains_reg;
            endcase
        end
    end

    // Output register loads a finished result and drops after its beat is taken.
    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        if (status.res_valid && res_ready)
        begin
            out_valid_next = 1'b1;
            out_data_next  = res_data;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gains_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            gains_reg     <= gains_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
    end

    ladrc_core #(
        .SAMPLE_RATE_HZ (SAMPLE_RATE_HZ)
    ) u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (in_accept),
        .in_item   (in_data),
        .gains     (gains_reg),
        .res_ready (res_ready),
        .status    (status),
        .res_data  (res_data),
        .mul_req   (mul_req),
        .mul_rsp   (mul_rsp)
    );

    ladrc_mul u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (mul_req),
        .rsp   (mul_rsp)
    );

endmodule
